### hdl/assert_macros.svh
// Assertion macros shared by the tokenizer RTL files.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every edge outside reset.
`define ASSERT_CLK(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Checked on every edge, reset included.
`define ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

### hdl/spt_pkg.sv
// Package for the script push tokenizer: types, codes and constants.
package spt_pkg;

    // Width of the script length and body byte counters (16 to 64)
    localparam int unsigned COUNT_BITS = 64;
    // Widest compact-size length field in bits
    localparam int unsigned PREFIX_BITS = 64;

    // Compact-size markers
    localparam logic [7:0] PREFIX_MARK16 = 8'hFD;
    localparam logic [7:0] PREFIX_MARK32 = 8'hFE;

    // Push opcodes
    localparam logic [7:0] DIRECT_PUSH_MIN = 8'd1;
    localparam logic [7:0] DIRECT_PUSH_MAX = 8'd75;
    localparam logic [7:0] PD8_OPCODE      = 8'd76;
    localparam logic [7:0] PD16_OPCODE     = 8'd77;
    localparam logic [7:0] PD32_OPCODE     = 8'd78;

    typedef logic [COUNT_BITS-1:0] t_count;

    typedef enum logic [2:0] {
        PH_PREFIX_FIRST = 3'd0,
        PH_PREFIX_MORE  = 3'd1,
        PH_OPCODE       = 3'd2,
        PH_PDLEN        = 3'd3,
        PH_DATA         = 3'd4,
        PH_DONE         = 3'd5
    } t_phase;

    typedef enum logic [2:0] {
        KIND_PREFIX    = 3'd0,
        KIND_OPCODE    = 3'd1,
        KIND_PUSH_LEN  = 3'd2,
        KIND_PD_OPCODE = 3'd3,
        KIND_PD_LEN    = 3'd4,
        KIND_DATA      = 3'd5,
        KIND_IGNORED   = 3'd6
    } t_kind;

    typedef struct packed {
        logic [7:0] in_byte;
        logic       end_of_buffer;
    } t_in_item;

    typedef struct packed {
        t_kind       byte_kind;
        logic [7:0]  byte_value;
        logic        element_done;
        logic        truncated;
        logic        script_done;
        logic        parse_error;
        logic [31:0] nominal_length;
    } t_out_item;

endpackage

### hdl/spt_parser.sv
// Parse state machine: tags one byte and updates the parse state per transfer.
`include "assert_macros.svh"

module spt_parser (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_advance,
    input  spt_pkg::t_in_item  i_item,
    output spt_pkg::t_out_item o_result
);

    spt_pkg::t_phase r_phase, n_phase;
    logic [2:0]      r_pos, n_pos;
    logic [3:0]      r_left, n_left;
    spt_pkg::t_count r_len, n_len;
    spt_pkg::t_count r_cons, n_cons;
    logic [31:0]     r_acc, n_acc;
    logic [31:0]     r_dleft, n_dleft;

    logic [7:0]                     b;
    logic [spt_pkg::PREFIX_BITS-1:0] lane_word;
    spt_pkg::t_count                cons_inc;
    spt_pkg::t_kind                 kind;
    logic                           edone, trunc, sdone, perr;
    logic                           count_en, check_en, ge;

    assign b         = i_item.in_byte;
    // Prefix byte placed at its little-endian lane
    assign lane_word = spt_pkg::PREFIX_BITS'(b) << {r_pos, 3'b000};
    // Saturating body byte count
    assign cons_inc  = (r_cons == '1) ? r_cons : r_cons + spt_pkg::COUNT_BITS'(1);

    // Next state and result tag
    always_comb begin
        n_phase  = r_phase;
        n_pos    = r_pos;
        n_left   = r_left;
        n_len    = r_len;
        n_cons   = r_cons;
        n_acc    = r_acc;
        n_dleft  = r_dleft;
        kind     = spt_pkg::KIND_IGNORED;
        edone    = 1'b0;
        trunc    = 1'b0;
        sdone    = 1'b0;
        perr     = 1'b0;
        count_en = 1'b0;
        check_en = 1'b0;

        case (r_phase)
            spt_pkg::PH_PREFIX_FIRST: begin
                kind = spt_pkg::KIND_PREFIX;
                if (b < spt_pkg::PREFIX_MARK16) begin
                    n_len    = spt_pkg::COUNT_BITS'(b);
                    n_cons   = '0;
                    check_en = 1'b1;
                end else begin
                    if (b == spt_pkg::PREFIX_MARK16) begin
                        n_left = 4'd2;
                    end else if (b == spt_pkg::PREFIX_MARK32) begin
                        n_left = 4'd4;
                    end else begin
                        n_left = 4'd8;
                    end
                    n_pos   = '0;
                    n_len   = '0;
                    n_phase = spt_pkg::PH_PREFIX_MORE;
                end
            end
            spt_pkg::PH_PREFIX_MORE: begin
                kind  = spt_pkg::KIND_PREFIX;
                n_len = r_len | lane_word[spt_pkg::COUNT_BITS-1:0];
                n_pos = r_pos + 3'd1;
                if (r_left != 4'd0) begin
                    n_left = r_left - 4'd1;
                end
                if (n_left == 4'd0) begin
                    n_cons   = '0;
                    check_en = 1'b1;
                end
            end
            spt_pkg::PH_OPCODE: begin
                count_en = 1'b1;
                if (b >= spt_pkg::DIRECT_PUSH_MIN && b <= spt_pkg::DIRECT_PUSH_MAX) begin
                    kind    = spt_pkg::KIND_PUSH_LEN;
                    n_acc   = 32'(b);
                    n_dleft = 32'(b);
                    n_phase = spt_pkg::PH_DATA;
                end else if (b == spt_pkg::PD8_OPCODE || b == spt_pkg::PD16_OPCODE
                             || b == spt_pkg::PD32_OPCODE) begin
                    kind  = spt_pkg::KIND_PD_OPCODE;
                    n_acc = '0;
                    if (b == spt_pkg::PD8_OPCODE) begin
                        n_left = 4'd1;
                    end else if (b == spt_pkg::PD16_OPCODE) begin
                        n_left = 4'd2;
                    end else begin
                        n_left = 4'd4;
                    end
                    n_pos   = '0;
                    n_phase = spt_pkg::PH_PDLEN;
                end else begin
                    kind     = spt_pkg::KIND_OPCODE;
                    edone    = 1'b1;
                    check_en = 1'b1;
                end
            end
            spt_pkg::PH_PDLEN: begin
                kind     = spt_pkg::KIND_PD_LEN;
                count_en = 1'b1;
                n_acc    = r_acc | (32'(b) << {r_pos[1:0], 3'b000});
                n_pos    = r_pos + 3'd1;
                if (r_left != 4'd0) begin
                    n_left = r_left - 4'd1;
                end
                if (n_left == 4'd0) begin
                    n_dleft = n_acc;
                    if (n_acc == 32'd0) begin
                        edone    = 1'b1;
                        check_en = 1'b1;
                    end else begin
                        n_phase = spt_pkg::PH_DATA;
                    end
                end
            end
            spt_pkg::PH_DATA: begin
                kind     = spt_pkg::KIND_DATA;
                count_en = 1'b1;
                if (r_dleft != 32'd0) begin
                    n_dleft = r_dleft - 32'd1;
                end
                if (n_dleft == 32'd0) begin
                    edone    = 1'b1;
                    check_en = 1'b1;
                end
            end
            default: begin
                kind = spt_pkg::KIND_IGNORED;
            end
        endcase

        if (count_en) begin
            n_cons = cons_inc;
        end

        // Completion check between elements
        ge = (n_cons >= n_len);
        if (check_en) begin
            if (ge) begin
                n_phase = spt_pkg::PH_DONE;
                sdone   = 1'b1;
            end else begin
                n_phase = spt_pkg::PH_OPCODE;
            end
        end

        o_result.byte_kind      = kind;
        o_result.byte_value     = b;
        o_result.nominal_length = n_acc;

        // Buffer end: flag the outcome, then rearm
        if (i_item.end_of_buffer) begin
            if (n_phase == spt_pkg::PH_DATA || n_phase == spt_pkg::PH_PDLEN) begin
                trunc = 1'b1;
                edone = 1'b1;
                if (ge) begin
                    sdone = 1'b1;
                end else begin
                    perr = 1'b1;
                end
            end else if (n_phase != spt_pkg::PH_DONE) begin
                perr = 1'b1;
            end
            n_phase = spt_pkg::PH_PREFIX_FIRST;
            n_pos   = '0;
            n_left  = '0;
            n_len   = '0;
            n_cons  = '0;
            n_acc   = '0;
            n_dleft = '0;
        end

        o_result.element_done = edone;
        o_result.truncated    = trunc;
        o_result.script_done  = sdone;
        o_result.parse_error  = perr;
    end

    // State registers, updated once per byte transfer
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= spt_pkg::PH_PREFIX_FIRST;
            r_pos   <= '0;
            r_left  <= '0;
            r_len   <= '0;
            r_cons  <= '0;
            r_acc   <= '0;
            r_dleft <= '0;
        end else if (i_advance) begin
            r_phase <= n_phase;
            r_pos   <= n_pos;
            r_left  <= n_left;
            r_len   <= n_len;
            r_cons  <= n_cons;
            r_acc   <= n_acc;
            r_dleft <= n_dleft;
        end
    end

    `ASSERT_CLK(a_eob_rearms, i_advance && i_item.end_of_buffer |=> r_phase == spt_pkg::PH_PREFIX_FIRST, "parser did not rearm after buffer end")
    `ASSERT_CLK(a_data_nonzero, r_phase == spt_pkg::PH_DATA |-> r_dleft != 32'd0, "data phase with nothing left")
    `ASSERT_CLK(a_pdlen_pending, r_phase == spt_pkg::PH_PDLEN |-> r_left != 4'd0, "pushdata length phase with no bytes due")

endmodule

### hdl/script_push_tokenizer.sv
// Script push tokenizer top level: input register, parser and result register.
//
// Usage: feed the serialized script one byte per transfer on the input channel
// (i_in_valid / o_in_stall, payload i_in_data) and set end_of_buffer on the
// last byte of each buffer. Each byte yields exactly one tag item on the
// output channel (o_out_valid / i_out_stall, payload o_out_data).
// An input transfer loads the byte into the input register; while it sits
// there the parser tags it and updates its state, and the tag is written
// to the output register as the byte advances.
// Throughput is one byte per cycle while the receiver does not stall; the
// limit per cycle is the parse state update, whose longest path is the
// saturating body count and its compare against the declared script length.
// When the receiver stalls, the result holds and the byte in the input
// register waits; o_in_stall rises once both registers are occupied.
// Reset (synchronous, i_rst_n low) empties both registers and returns the
// parser to expect the first length prefix byte. A byte with end_of_buffer
// set rearms the parser the same way for the next buffer.
`include "assert_macros.svh"

module script_push_tokenizer (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  spt_pkg::t_in_item  i_in_data,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output spt_pkg::t_out_item o_out_data
);

    logic               r_in_valid;
    spt_pkg::t_in_item  r_in_item;
    logic               r_out_valid;
    spt_pkg::t_out_item r_out_item;

    logic               advance;
    logic               in_xfer;
    spt_pkg::t_out_item result;

    // Move a byte from the input register to the result register
    assign advance    = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall = r_in_valid && !advance;
    assign in_xfer    = i_in_valid && !o_in_stall;

    spt_parser u_parser (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_item    (r_in_item),
        .o_result  (result)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_item <= i_in_data;
        end
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_item <= result;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_item;

    `ASSERT_CLK(a_advance_fills, advance |=> o_out_valid, "result register not loaded after advance")

endmodule
